@@ hdl/bhmc_pkg.sv @@
// ----------------------------------------------------------------------------
// bhmc_pkg
// Shared types and codes for the button hold and multi-click detector.
// ----------------------------------------------------------------------------
package bhmc_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned GEST_W   = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // gesture codes
    localparam logic [GEST_W-1:0] GEST_NONE  = 2'd0;
    localparam logic [GEST_W-1:0] GEST_HOLD  = 2'd1;
    localparam logic [GEST_W-1:0] GEST_MULTI = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_WINDOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICKS       = 3'd4;

    typedef struct packed {
        logic [7:0]         debounce_ms;
        logic [15:0]        hold_ms;
        logic [15:0]        click_max_ms;
        logic [15:0]        multi_click_window_ms;
        logic [COUNT_W-1:0] clicks_needed;
    } bhmc_cfg_t;

    typedef struct packed {
        logic               is_down;
        logic               in_release;
        logic               hold_reported;
        logic [TIME_W-1:0]  press_start_time;
        logic [TIME_W-1:0]  release_start_time;
        logic [TIME_W-1:0]  last_press_length;
        logic [COUNT_W-1:0] click_count;
        logic [TIME_W-1:0]  first_click_time;
    } bhmc_state_t;

endpackage

@@ hdl/bhmc_step.sv @@
// ----------------------------------------------------------------------------
// bhmc_step
// One sample step: debounce, hold detection and click counting.
// ----------------------------------------------------------------------------
module bhmc_step (
    input  bhmc_pkg::bhmc_cfg_t               cfg,
    input  bhmc_pkg::bhmc_state_t             state,
    input  logic                              pressed,
    input  logic [bhmc_pkg::TIME_W-1:0]       now_ms,
    output bhmc_pkg::bhmc_state_t             state_next,
    output logic [bhmc_pkg::GEST_W-1:0]       gesture,
    output logic [bhmc_pkg::TIME_W-1:0]       held_ms
);

    logic [bhmc_pkg::TIME_W-1:0]  since_press;
    logic [bhmc_pkg::TIME_W-1:0]  since_release;
    logic [bhmc_pkg::TIME_W-1:0]  since_first;
    logic [bhmc_pkg::TIME_W-1:0]  press_len;
    logic                         debounced;
    logic                         restart;
    logic                         hold_done;
    logic [bhmc_pkg::COUNT_W-1:0] count_new;

    assign since_press   = now_ms - state.press_start_time;
    assign since_release = now_ms - state.release_start_time;
    assign since_first   = now_ms - state.first_click_time;
    assign debounced     = since_release >= {24'd0, cfg.debounce_ms};

    // a fresh press starts its timer at zero
    assign restart   = !state.is_down && !(state.in_release && !debounced);
    assign press_len = restart ? '0 : since_press;
    assign hold_done = restart ? 1'b0 : state.hold_reported;

    always_comb begin
        state_next = state;
        gesture    = bhmc_pkg::GEST_NONE;
        held_ms    = '0;
        count_new  = '0;
        if (pressed) begin
            state_next.is_down    = 1'b1;
            state_next.in_release = 1'b0;
            if (restart) begin
                state_next.press_start_time = now_ms;
                state_next.hold_reported    = 1'b0;
            end
            if (!hold_done && press_len >= {16'd0, cfg.hold_ms}) begin
                state_next.hold_reported = 1'b1;
                state_next.click_count   = '0;
                gesture                  = bhmc_pkg::GEST_HOLD;
            end
            held_ms = press_len;
        end else if (state.is_down) begin
            state_next.is_down            = 1'b0;
            state_next.in_release         = 1'b1;
            state_next.release_start_time = now_ms;
            state_next.last_press_length  = since_press;
        end else if (state.in_release && debounced) begin
            state_next.in_release    = 1'b0;
            state_next.hold_reported = 1'b0;
            if (state.last_press_length >= {16'd0, cfg.click_max_ms}) begin
                state_next.click_count = '0;
            end else begin
                // window opens at the first click of a run
                if (state.click_count == '0
                        || since_first > {16'd0, cfg.multi_click_window_ms}) begin
                    count_new                   = 4'd1;
                    state_next.first_click_time = now_ms;
                end else begin
                    count_new = state.click_count + 4'd1;
                end
                if (count_new >= cfg.clicks_needed) begin
                    state_next.click_count = '0;
                    gesture                = bhmc_pkg::GEST_MULTI;
                end else begin
                    state_next.click_count = count_new;
                end
            end
        end
    end

endmodule

@@ hdl/button_hold_and_multiclick_detector.sv @@
// ----------------------------------------------------------------------------
// button_hold_and_multiclick_detector
// Debounced button sampler that reports long holds and multi-click runs.
// ----------------------------------------------------------------------------
// Takes one button sample per beat on the s_ channel and returns exactly one
// result beat on the m_ channel for each, in order. A sample can be accepted
// every clock cycle unless a result waiting on m_tready holds the input
// register. A sample is loaded into the input register when it is accepted,
// and its result is loaded into the result register when the step advances.
// The combinational step logic between the two registers also updates the
// detector state. A result waiting on m_tready keeps a registered sample from
// advancing, and the next sample is then not accepted. Timing registers are
// written through the cfg_ port, which is always ready; write them only while
// no sample is in flight.
// ----------------------------------------------------------------------------
module button_hold_and_multiclick_detector (
    input  logic        aclk,
    input  logic        aresetn,
    // sample channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [0] pressed, [32:1] now_ms, rest zero
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [1:0] gesture, [33:2] held_ms, rest zero
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bhmc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bhmc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    bhmc_pkg::bhmc_cfg_t   cfg_reg;
    bhmc_pkg::bhmc_state_t state_reg;
    bhmc_pkg::bhmc_state_t state_next;

    logic                          in_valid_reg;
    logic                          pressed_reg;
    logic [bhmc_pkg::TIME_W-1:0]   now_reg;
    logic                          m_valid_reg;
    logic [bhmc_pkg::GEST_W-1:0]   gesture_reg;
    logic [bhmc_pkg::TIME_W-1:0]   held_reg;
    logic [bhmc_pkg::GEST_W-1:0]   gesture_next;
    logic [bhmc_pkg::TIME_W-1:0]   held_next;
    logic                          advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'd0, held_reg, gesture_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms           <= 8'd30;
            cfg_reg.hold_ms               <= 16'd2000;
            cfg_reg.click_max_ms          <= 16'd400;
            cfg_reg.multi_click_window_ms <= 16'd1500;
            cfg_reg.clicks_needed         <= 4'd3;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                bhmc_pkg::CFG_DEBOUNCE:     cfg_reg.debounce_ms <= cfg_data[7:0];
                bhmc_pkg::CFG_HOLD:         cfg_reg.hold_ms <= cfg_data;
                bhmc_pkg::CFG_CLICK_MAX:    cfg_reg.click_max_ms <= cfg_data;
                bhmc_pkg::CFG_CLICK_WINDOW: cfg_reg.multi_click_window_ms <= cfg_data;
                bhmc_pkg::CFG_CLICKS:       cfg_reg.clicks_needed <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    bhmc_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .pressed    (pressed_reg),
        .now_ms     (now_reg),
        .state_next (state_next),
        .gesture    (gesture_next),
        .held_ms    (held_next)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            pressed_reg <= s_tdata[0];
            now_reg     <= s_tdata[32:1];
        end
    end

    // state and result register move together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            state_reg   <= state_next;
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            gesture_reg <= gesture_next;
            held_reg    <= held_next;
        end
    end

`ifndef SYNTH
    // a nonzero held time on a waiting beat means the button is still down
    a_held_down: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && held_reg != '0 |-> state_reg.is_down)
        else $error("held time reported while released");

    a_hold_down: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && gesture_reg == bhmc_pkg::GEST_HOLD |-> state_reg.is_down)
        else $error("hold reported while released");

    a_release_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg.is_down && state_reg.in_release))
        else $error("pressed and releasing at once");

    // count clears on reaching the target, so it never settles at all ones
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.click_count != 4'hf)
        else $error("click count overran");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("state changed without a beat");
`endif

endmodule
